### sv/rfrc_pkg.sv
// Types, constants and helpers shared by the radio frame receive checker.
`timescale 1ns / 1ps
`default_nettype none
package rfrc_pkg;

	localparam logic [7:0] HeaderBytes = 8'd4;
	localparam logic [7:0] FirstDataPos = 8'd5;

	localparam logic [2:0] STAT_GOOD      = 3'd0;
	localparam logic [2:0] STAT_BAD_ADDR  = 3'd1;
	localparam logic [2:0] STAT_UNDERSIZE = 3'd2;
	localparam logic [2:0] STAT_BAD_LEN   = 3'd3;
	localparam logic [2:0] STAT_BAD_CSUM  = 3'd4;

	localparam logic [1:0] REG_NODE_ADDR  = 2'd0;
	localparam logic [1:0] REG_BCAST_ADDR = 2'd1;
	localparam logic [1:0] REG_MAX_LEN    = 2'd2;
	localparam logic [1:0] REG_DATA_LEN   = 2'd3;

	localparam logic [7:0] RST_NODE_ADDR  = 8'd0;
	localparam logic [7:0] RST_BCAST_ADDR = 8'd255;
	localparam logic [7:0] RST_MAX_LEN    = 8'd61;
	localparam logic [7:0] RST_DATA_LEN   = 8'd11;

	typedef struct packed {
		logic [7:0] rx_byte;
		logic       frame_start;
	} rfrc_in_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       data_valid;
		logic [7:0] data_index;
		logic       frame_end;
		logic [2:0] status;
		logic [7:0] sender_id;
		logic [7:0] message_id;
		logic [7:0] control_byte;
	} rfrc_out_t;

	typedef struct packed {
		logic [7:0] node_address;
		logic [7:0] broadcast_address;
		logic [7:0] max_payload_len;
		logic [7:0] expected_data_len;
	} rfrc_cfg_t;

	// end-of-frame verdict: data length first, then checksum
	function automatic logic [2:0] verdict(
		input logic [7:0] frame_len,
		input logic [7:0] exp_len,
		input logic [7:0] xor_sum,
		input logic [7:0] csum
	);
		logic [7:0] dlen;
		dlen = frame_len - HeaderBytes;
		if (dlen != exp_len) begin
			return STAT_BAD_LEN;
		end else if (xor_sum != csum) begin
			return STAT_BAD_CSUM;
		end
		return STAT_GOOD;
	endfunction

endpackage
`default_nettype wire

### sv/radio_frame_receive_checker_top.sv
// Top level of the radio frame receive checker.
// Usage:
//   byte channel (byte_valid/byte_ready/byte_data) takes one received byte per
//   transaction; frame_start marks the length byte that opens a frame.
//   res channel (res_valid/res_ready/res_data) returns exactly one result per
//   byte: data bytes with their index, and the verdict with frame_end.
//   APB port sets node and broadcast address, length clamp, expected data len.
// Path: an accepted byte lands in the input register; its parse result then
//   lands in the result register, which drives res_valid and res_data.
//   Throughput: one byte per cycle while res_ready holds; parse is combinational.
// Reset clears the frame state (idle, discarding until a frame start), the
//   pipeline valids and loads the register defaults.
// When the receiver stalls the result register holds; one more byte waits in
//   the input register, then byte_ready drops until res_ready returns.
`timescale 1ns / 1ps
`default_nettype none
module radio_frame_receive_checker_top (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              byte_valid,
	output logic                   byte_ready,
	input  wire rfrc_pkg::rfrc_in_t byte_data,
	output logic                   res_valid,
	input  wire logic              res_ready,
	output rfrc_pkg::rfrc_out_t    res_data,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [3:0]        paddr,
	input  wire logic [31:0]       pwdata,
	output logic [31:0]            prdata,
	output logic                   pready
);

	rfrc_pkg::rfrc_cfg_t cfg;
	rfrc_pkg::rfrc_in_t  item_s1;
	rfrc_pkg::rfrc_out_t result_s2;
	rfrc_pkg::rfrc_out_t result;
	logic                valid_s1, valid_s2;
	logic                adv_s2, adv_s1;

	rfrc_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	assign adv_s2     = !valid_s2 || res_ready;
	assign adv_s1     = valid_s1 && adv_s2;
	assign byte_ready = !valid_s1 || adv_s2;

	rfrc_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.item   (item_s1),
		.step   (adv_s1),
		.result (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (byte_ready) begin
				valid_s1 <= byte_valid;
			end
			if (adv_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (byte_ready && byte_valid) begin
			item_s1 <= byte_data;
		end
		if (adv_s1) begin
			result_s2 <= result;
		end
	end

	assign res_valid = valid_s2;
	assign res_data  = result_s2;

endmodule
`default_nettype wire

### sv/rfrc_regs.sv
// APB configuration registers of the frame checker.
`timescale 1ns / 1ps
`default_nettype none
module rfrc_regs (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [3:0]        paddr,
	input  wire logic [31:0]       pwdata,
	output logic [31:0]            prdata,
	output logic                   pready,
	output rfrc_pkg::rfrc_cfg_t    cfg
);

	rfrc_pkg::rfrc_cfg_t cfg_q;
	logic                wr_en;
	logic [1:0]          reg_idx;
	logic [7:0]          rd_byte;

	assign pready  = 1'b1;
	assign wr_en   = psel & penable & pwrite;
	assign reg_idx = paddr[3:2];
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.node_address      <= rfrc_pkg::RST_NODE_ADDR;
			cfg_q.broadcast_address <= rfrc_pkg::RST_BCAST_ADDR;
			cfg_q.max_payload_len   <= rfrc_pkg::RST_MAX_LEN;
			cfg_q.expected_data_len <= rfrc_pkg::RST_DATA_LEN;
		end else if (wr_en) begin
			unique case (reg_idx)
				rfrc_pkg::REG_NODE_ADDR:  cfg_q.node_address      <= pwdata[7:0];
				rfrc_pkg::REG_BCAST_ADDR: cfg_q.broadcast_address <= pwdata[7:0];
				rfrc_pkg::REG_MAX_LEN:    cfg_q.max_payload_len   <= pwdata[7:0];
				rfrc_pkg::REG_DATA_LEN:   cfg_q.expected_data_len <= pwdata[7:0];
				default:                  cfg_q.node_address      <= cfg_q.node_address;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			rfrc_pkg::REG_NODE_ADDR:  rd_byte = cfg_q.node_address;
			rfrc_pkg::REG_BCAST_ADDR: rd_byte = cfg_q.broadcast_address;
			rfrc_pkg::REG_MAX_LEN:    rd_byte = cfg_q.max_payload_len;
			rfrc_pkg::REG_DATA_LEN:   rd_byte = cfg_q.expected_data_len;
			default:                  rd_byte = 8'd0;
		endcase
	end

	assign prdata = {24'd0, rd_byte};

endmodule
`default_nettype wire

### sv/rfrc_core.sv
// Frame state and per-byte parse logic: header capture, filter, XOR check.
`timescale 1ns / 1ps
`default_nettype none
module rfrc_core (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire rfrc_pkg::rfrc_cfg_t cfg,
	input  wire rfrc_pkg::rfrc_in_t  item,
	input  wire logic              step,
	output rfrc_pkg::rfrc_out_t    result
);

	logic [7:0] byte_pos_q, frame_len_q, xor_sum_q, csum_q;
	logic [7:0] sender_q, msgid_q, control_q;
	logic       in_frame_q;

	logic [7:0] byte_pos_d, frame_len_d, xor_sum_d, csum_d;
	logic [7:0] sender_d, msgid_d, control_d;
	logic       in_frame_d;

	logic [7:0] pos, idx, dlen, b;
	logic       last_data;

	assign b    = item.rx_byte;
	assign pos  = byte_pos_q + 8'd1;
	assign idx  = pos - rfrc_pkg::FirstDataPos;
	assign dlen = frame_len_q - rfrc_pkg::HeaderBytes;
	assign last_data = ({1'b0, idx} + 9'd1) >= {1'b0, dlen};

	always_comb begin
		byte_pos_d  = byte_pos_q;
		frame_len_d = frame_len_q;
		in_frame_d  = in_frame_q;
		xor_sum_d   = xor_sum_q;
		csum_d      = csum_q;
		sender_d    = sender_q;
		msgid_d     = msgid_q;
		control_d   = control_q;
		result      = '0;

		if (item.frame_start) begin
			frame_len_d = (b > cfg.max_payload_len) ? cfg.max_payload_len : b;
			in_frame_d  = 1'b1;
			byte_pos_d  = 8'd0;
			xor_sum_d   = 8'd0;
			csum_d      = 8'd0;
			sender_d    = 8'd0;
			msgid_d     = 8'd0;
			control_d   = 8'd0;
		end else if (in_frame_q) begin
			byte_pos_d = pos;
			unique case (pos)
				8'd1: begin
					if (b != cfg.node_address && b != cfg.broadcast_address) begin
						result.frame_end = 1'b1;
						result.status    = rfrc_pkg::STAT_BAD_ADDR;
						in_frame_d       = 1'b0;
					end else if (frame_len_q < rfrc_pkg::HeaderBytes) begin
						result.frame_end = 1'b1;
						result.status    = rfrc_pkg::STAT_UNDERSIZE;
						in_frame_d       = 1'b0;
					end
				end
				8'd2: sender_d = b;
				8'd3: msgid_d  = b;
				rfrc_pkg::HeaderBytes: begin
					control_d = b;
					if (frame_len_q == rfrc_pkg::HeaderBytes) begin
						result.frame_end = 1'b1;
						result.status    = rfrc_pkg::verdict(frame_len_q,
							cfg.expected_data_len, xor_sum_q, csum_q);
						in_frame_d       = 1'b0;
					end
				end
				default: begin
					result.data_byte  = b;
					result.data_valid = 1'b1;
					result.data_index = idx;
					if (!last_data) begin
						xor_sum_d = xor_sum_q ^ b;
					end else begin
						csum_d           = b;
						result.frame_end = 1'b1;
						result.status    = rfrc_pkg::verdict(frame_len_q,
							cfg.expected_data_len, xor_sum_q, b);
						in_frame_d       = 1'b0;
					end
				end
			endcase
		end

		result.sender_id    = sender_d;
		result.message_id   = msgid_d;
		result.control_byte = control_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_pos_q  <= 8'd0;
			frame_len_q <= 8'd0;
			in_frame_q  <= 1'b0;
			xor_sum_q   <= 8'd0;
			csum_q      <= 8'd0;
			sender_q    <= 8'd0;
			msgid_q     <= 8'd0;
			control_q   <= 8'd0;
		end else if (step) begin
			byte_pos_q  <= byte_pos_d;
			frame_len_q <= frame_len_d;
			in_frame_q  <= in_frame_d;
			xor_sum_q   <= xor_sum_d;
			csum_q      <= csum_d;
			sender_q    <= sender_d;
			msgid_q     <= msgid_d;
			control_q   <= control_d;
		end
	end

endmodule
`default_nettype wire

### sv/rfrc_checker.sv
// Port-level checker for the frame checker, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module rfrc_checker (
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              byte_ready,
	input wire logic              res_valid,
	input wire logic              res_ready,
	input wire rfrc_pkg::rfrc_out_t res_data
);

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_data))
		else $error("result changed while stalled");

	a_status_only_at_end: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_data.frame_end |-> res_data.status == rfrc_pkg::STAT_GOOD)
		else $error("status set without frame end");

	a_data_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_data.data_valid |->
			res_data.data_byte == 8'd0 && res_data.data_index == 8'd0)
		else $error("data fields set without data_valid");

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!res_valid |-> byte_ready)
		else $error("input stalled with empty result stage");

endmodule

bind radio_frame_receive_checker_top rfrc_checker u_rfrc_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.byte_ready (byte_ready),
	.res_valid  (res_valid),
	.res_ready  (res_ready),
	.res_data   (res_data)
);
`default_nettype wire

### test/tb_radio_frame_receive_checker_top.sv
// Self-checking testbench for the radio frame receive checker: directed table, then random frames.
`timescale 1ns / 1ps
module tb_radio_frame_receive_checker_top;

	typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

	typedef struct {
		row_kind_t            kind;
		logic [1:0]           sel;
		logic [7:0]           val;
		bit                   typed;
		rfrc_pkg::rfrc_out_t  want;
	} dir_row_t;

	localparam int DirRows = 31;
	localparam int Phases = 8;
	localparam rfrc_pkg::rfrc_out_t NoResult = '0;

	logic                clk;
	logic                arst_n;
	logic                byte_valid;
	logic                byte_ready;
	rfrc_pkg::rfrc_in_t  byte_data;
	logic                res_valid;
	logic                res_ready;
	rfrc_pkg::rfrc_out_t res_data;
	logic                psel;
	logic                penable;
	logic                pwrite;
	logic [3:0]          paddr;
	logic [31:0]         pwdata;
	logic [31:0]         prdata;
	logic                pready;

	rfrc_pkg::rfrc_cfg_t cur_cfg;
	logic [7:0] pos_cnt;
	logic [7:0] frm_len;
	logic [7:0] xor_acc;
	logic [7:0] csum_last;
	logic [7:0] snd_q;
	logic [7:0] mid_q;
	logic [7:0] ctl_q;
	logic       frm_open;
	bit         byte_ignored;

	rfrc_pkg::rfrc_out_t frame_results_due[$];
	int        fail_cnt;
	int        results_seen;
	bit        quiet;

	dir_row_t            dir_tab [0:DirRows-1];
	rfrc_pkg::rfrc_cfg_t phase_cfg [0:Phases-1];
	int                  phase_budget [0:Phases-1];

	radio_frame_receive_checker_top uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_valid),
		.byte_ready (byte_ready),
		.byte_data  (byte_data),
		.res_valid  (res_valid),
		.res_ready  (res_ready),
		.res_data   (res_data),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#3000000;
		$display("tb_radio_frame_receive_checker_top: FAIL");
		$finish;
	end

	function automatic logic [2:0] judge_frame();
		logic [7:0] dlen;
		dlen = frm_len - rfrc_pkg::HeaderBytes;
		if (dlen != cur_cfg.expected_data_len) begin
			return rfrc_pkg::STAT_BAD_LEN;
		end
		if (xor_acc != csum_last) begin
			return rfrc_pkg::STAT_BAD_CSUM;
		end
		return rfrc_pkg::STAT_GOOD;
	endfunction

	function automatic rfrc_pkg::rfrc_out_t parse_rx_byte(input rfrc_pkg::rfrc_in_t it);
		rfrc_pkg::rfrc_out_t r;
		logic [7:0] b;
		logic [7:0] idx;
		logic [7:0] dlen;
		r = '0;
		b = it.rx_byte;
		byte_ignored = 1'b0;
		if (it.frame_start) begin
			frm_len = (b > cur_cfg.max_payload_len) ? cur_cfg.max_payload_len : b;
			frm_open = 1'b1;
			pos_cnt = 8'd0;
			xor_acc = 8'd0;
			csum_last = 8'd0;
			snd_q = 8'd0;
			mid_q = 8'd0;
			ctl_q = 8'd0;
		end else if (frm_open) begin
			pos_cnt = pos_cnt + 8'd1;
			if (pos_cnt == 8'd1) begin
				if (b != cur_cfg.node_address && b != cur_cfg.broadcast_address) begin
					r.frame_end = 1'b1;
					r.status = rfrc_pkg::STAT_BAD_ADDR;
					frm_open = 1'b0;
				end else if (frm_len < rfrc_pkg::HeaderBytes) begin
					r.frame_end = 1'b1;
					r.status = rfrc_pkg::STAT_UNDERSIZE;
					frm_open = 1'b0;
				end
			end else if (pos_cnt == 8'd2) begin
				snd_q = b;
			end else if (pos_cnt == 8'd3) begin
				mid_q = b;
			end else if (pos_cnt == rfrc_pkg::HeaderBytes) begin
				ctl_q = b;
				if (frm_len == rfrc_pkg::HeaderBytes) begin
					r.frame_end = 1'b1;
					r.status = judge_frame();
					frm_open = 1'b0;
				end
			end else begin
				idx = pos_cnt - rfrc_pkg::FirstDataPos;
				dlen = frm_len - rfrc_pkg::HeaderBytes;
				r.data_byte = b;
				r.data_valid = 1'b1;
				r.data_index = idx;
				if (idx + 8'd1 < dlen) begin
					xor_acc = xor_acc ^ b;
				end else begin
					csum_last = b;
					r.frame_end = 1'b1;
					r.status = judge_frame();
					frm_open = 1'b0;
				end
			end
		end else begin
			byte_ignored = 1'b1;
		end
		r.sender_id = snd_q;
		r.message_id = mid_q;
		r.control_byte = ctl_q;
		return r;
	endfunction

	task automatic send_byte(input rfrc_pkg::rfrc_in_t it, input bit typed,
		input rfrc_pkg::rfrc_out_t want);
		rfrc_pkg::rfrc_out_t pred;
		while (!quiet && $urandom_range(0, 99) < 8) begin
			byte_valid <= 1'b0;
			@(posedge clk);
		end
		byte_valid <= 1'b1;
		byte_data <= it;
		@(posedge clk);
		while (!byte_ready) begin
			@(posedge clk);
		end
		pred = parse_rx_byte(it);
		frame_results_due.push_back(typed ? want : pred);
	endtask

	task automatic apb_write(input logic [1:0] sel, input logic [7:0] val);
		byte_valid <= 1'b0;
		while (frame_results_due.size() != 0) begin
			@(posedge clk);
		end
		repeat (4) @(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {sel, 2'b00};
		pwdata <= {24'd0, val};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (sel)
			rfrc_pkg::REG_NODE_ADDR: begin
				cur_cfg.node_address = val;
			end
			rfrc_pkg::REG_BCAST_ADDR: begin
				cur_cfg.broadcast_address = val;
			end
			rfrc_pkg::REG_MAX_LEN: begin
				cur_cfg.max_payload_len = val;
			end
			default: begin
				cur_cfg.expected_data_len = val;
			end
		endcase
	endtask

	// result side: checking, random stall, one long hold-off
	initial begin
		rfrc_pkg::rfrc_out_t want;
		int        hold_left;
		bit        hold_done;
		res_ready <= 1'b0;
		hold_left = 0;
		hold_done = 1'b0;
		results_seen = 0;
		forever begin
			@(posedge clk);
			if (res_valid && res_ready) begin
				results_seen++;
				if (frame_results_due.size() == 0) begin
					$error("unexpected result transaction %0h", res_data);
					fail_cnt++;
				end else begin
					want = frame_results_due.pop_front();
					if (res_data.data_byte !== want.data_byte) begin
						$error("data_byte exp %0h got %0h", want.data_byte, res_data.data_byte);
						fail_cnt++;
					end
					if (res_data.data_valid !== want.data_valid) begin
						$error("data_valid exp %0h got %0h", want.data_valid, res_data.data_valid);
						fail_cnt++;
					end
					if (res_data.data_index !== want.data_index) begin
						$error("data_index exp %0h got %0h", want.data_index, res_data.data_index);
						fail_cnt++;
					end
					if (res_data.frame_end !== want.frame_end) begin
						$error("frame_end exp %0h got %0h", want.frame_end, res_data.frame_end);
						fail_cnt++;
					end
					if (res_data.status !== want.status) begin
						$error("status exp %0h got %0h", want.status, res_data.status);
						fail_cnt++;
					end
					if (res_data.sender_id !== want.sender_id) begin
						$error("sender_id exp %0h got %0h", want.sender_id, res_data.sender_id);
						fail_cnt++;
					end
					if (res_data.message_id !== want.message_id) begin
						$error("message_id exp %0h got %0h", want.message_id, res_data.message_id);
						fail_cnt++;
					end
					if (res_data.control_byte !== want.control_byte) begin
						$error("control_byte exp %0h got %0h", want.control_byte,
							res_data.control_byte);
						fail_cnt++;
					end
				end
			end
			if (!hold_done && results_seen >= 450) begin
				hold_left = 300;
				hold_done = 1'b1;
			end
			if (hold_left > 0) begin
				res_ready <= 1'b0;
				hold_left--;
			end else begin
				res_ready <= quiet || ($urandom_range(0, 99) >= 8);
			end
		end
	end

	initial begin
		rfrc_pkg::rfrc_in_t  item;
		rfrc_pkg::rfrc_cfg_t cfg;
		int         ph;
		int         count;
		int         roll;
		int         dlen;
		int         len_i;
		int         cl;
		int         cut;
		int         k;
		bit         well;
		logic [7:0] tgt;
		logic [7:0] b;
		logic [7:0] run;

		arst_n <= 1'b0;
		byte_valid <= 1'b0;
		byte_data <= '0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		quiet = 1'b0;
		fail_cnt = 0;
		cur_cfg = '{rfrc_pkg::RST_NODE_ADDR, rfrc_pkg::RST_BCAST_ADDR,
			rfrc_pkg::RST_MAX_LEN, rfrc_pkg::RST_DATA_LEN};
		pos_cnt = '0;
		frm_len = '0;
		xor_acc = '0;
		csum_last = '0;
		snd_q = '0;
		mid_q = '0;
		ctl_q = '0;
		frm_open = 1'b0;

		dir_tab = '{
			'{ROW_ITEM, 2'd0, 8'h55, 1'b1, NoResult},
			'{ROW_ITEM, 2'd1, 8'hFF, 1'b1, NoResult},
			'{ROW_ITEM, 2'd0, 8'h12, 1'b1,
				'{8'h00, 1'b0, 8'h00, 1'b1, rfrc_pkg::STAT_BAD_ADDR, 8'h00, 8'h00, 8'h00}},
			'{ROW_ITEM, 2'd1, 8'h02, 1'b1, NoResult},
			'{ROW_ITEM, 2'd0, 8'hFF, 1'b1,
				'{8'h00, 1'b0, 8'h00, 1'b1, rfrc_pkg::STAT_UNDERSIZE, 8'h00, 8'h00, 8'h00}},
			'{ROW_ITEM, 2'd1, 8'h05, 1'b1, NoResult},
			'{ROW_ITEM, 2'd0, 8'h00, 1'b0, NoResult},
			'{ROW_ITEM, 2'd0, 8'hA5, 1'b0, NoResult},
			// restart inside an open frame drops the header
			'{ROW_ITEM, 2'd1, 8'h04, 1'b1, NoResult},
			'{ROW_ITEM, 2'd0, 8'hFF, 1'b0, NoResult},
			'{ROW_ITEM, 2'd0, 8'h00, 1'b0, NoResult},
			'{ROW_ITEM, 2'd0, 8'hFF, 1'b0, NoResult},
			'{ROW_ITEM, 2'd0, 8'h81, 1'b1,
				'{8'h00, 1'b0, 8'h00, 1'b1, rfrc_pkg::STAT_BAD_LEN, 8'h00, 8'hFF, 8'h81}},
			'{ROW_ITEM, 2'd1, 8'h07, 1'b0, NoResult},
			'{ROW_ITEM, 2'd0, 8'h00, 1'b0, NoResult},
			'{ROW_ITEM, 2'd0, 8'h5A, 1'b0, NoResult},
			'{ROW_ITEM, 2'd0, 8'hC3, 1'b0, NoResult},
			'{ROW_ITEM, 2'd0, 8'h3C, 1'b0, NoResult},
			'{ROW_ITEM, 2'd0, 8'hFF, 1'b0, NoResult},
			'{ROW_ITEM, 2'd0, 8'h00, 1'b0, NoResult},
			'{ROW_ITEM, 2'd0, 8'hAA, 1'b0, NoResult},
			'{ROW_CFG, rfrc_pkg::REG_DATA_LEN, 8'd2, 1'b0, NoResult},
			'{ROW_CFG, rfrc_pkg::REG_NODE_ADDR, 8'hC3, 1'b0, NoResult},
			'{ROW_CFG, rfrc_pkg::REG_BCAST_ADDR, 8'h00, 1'b0, NoResult},
			'{ROW_CFG, rfrc_pkg::REG_MAX_LEN, 8'd255, 1'b0, NoResult},
			'{ROW_ITEM, 2'd1, 8'h06, 1'b0, NoResult},
			'{ROW_ITEM, 2'd0, 8'hC3, 1'b0, NoResult},
			'{ROW_ITEM, 2'd0, 8'h11, 1'b0, NoResult},
			'{ROW_ITEM, 2'd0, 8'h22, 1'b0, NoResult},
			'{ROW_ITEM, 2'd0, 8'h9E, 1'b0, NoResult},
			'{ROW_ITEM, 2'd0, 8'h9E, 1'b0, NoResult}
		};

		phase_cfg = '{
			'{8'h3A, 8'hFF, 8'd61, 8'd2},
			'{8'hFF, 8'h00, 8'd255, 8'd251},
			'{8'h81, 8'h7E, 8'd4, 8'd0},
			'{8'h10, 8'h10, 8'd3, 8'd1},
			'{8'h55, 8'hAA, 8'd20, 8'd8},
			'{8'h00, 8'hFF, 8'd12, 8'd1},
			'{8'h00, 8'h00, 8'd4, 8'd2},
			'{8'h00, 8'h00, 8'd4, 8'd2}
		};
		phase_budget = '{100, 320, 80, 60, 120, 80, 100, 100};

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < DirRows; i++) begin
			if (dir_tab[i].kind == ROW_CFG) begin
				apb_write(dir_tab[i].sel, dir_tab[i].val);
			end else begin
				item.rx_byte = dir_tab[i].val;
				item.frame_start = dir_tab[i].sel[0];
				send_byte(item, dir_tab[i].typed, dir_tab[i].want);
			end
		end

		for (ph = 0; ph < Phases; ph++) begin
			cfg = phase_cfg[ph];
			if (ph >= 6) begin
				cfg.node_address = 8'($urandom_range(0, 255));
				cfg.broadcast_address = 8'($urandom_range(0, 255));
				cfg.max_payload_len = 8'($urandom_range(4, 40));
				cfg.expected_data_len = 8'($urandom_range(2, 36));
			end
			apb_write(rfrc_pkg::REG_NODE_ADDR, cfg.node_address);
			apb_write(rfrc_pkg::REG_BCAST_ADDR, cfg.broadcast_address);
			apb_write(rfrc_pkg::REG_MAX_LEN, cfg.max_payload_len);
			apb_write(rfrc_pkg::REG_DATA_LEN, cfg.expected_data_len);
			quiet = (ph == 4);
			count = 0;
			while (count < phase_budget[ph]) begin
				roll = $urandom_range(0, 99);
				if (roll < 6) begin
					item.rx_byte = 8'($urandom_range(0, 255));
					item.frame_start = 1'b0;
					send_byte(item, 1'b0, NoResult);
					count += byte_ignored ? 0 : 1;
				end else begin
					well = (roll < 80);
					if (well) begin
						dlen = cfg.expected_data_len;
						if ($urandom_range(0, 9) == 0) begin
							dlen++;
						end
					end else begin
						dlen = $urandom_range(0, 12);
					end
					len_i = dlen + 4;
					if (len_i > 255) begin
						len_i = 255;
					end
					if ($urandom_range(0, 4) == 0) begin
						len_i = $urandom_range(len_i, 255);
					end
					if (!well && $urandom_range(0, 2) == 0) begin
						len_i = $urandom_range(0, 255);
					end
					cl = (len_i > cfg.max_payload_len) ? cfg.max_payload_len : len_i;
					tgt = $urandom_range(0, 1) ? cfg.node_address : cfg.broadcast_address;
					if (!well && $urandom_range(0, 1)) begin
						tgt = 8'($urandom_range(0, 255));
					end
					cut = well ? cl : $urandom_range(0, cl);
					item.rx_byte = 8'(len_i);
					item.frame_start = 1'b1;
					send_byte(item, 1'b0, NoResult);
					count++;
					run = 8'd0;
					for (k = 1; k <= cut && frm_open; k++) begin
						if (k == 1) begin
							b = tgt;
						end else if (k > 4 && k == cl && well && $urandom_range(0, 6) != 0) begin
							b = run;
						end else begin
							b = 8'($urandom_range(0, 255));
						end
						if (k > 4 && k < cl) begin
							run = run ^ b;
						end
						item.rx_byte = b;
						item.frame_start = 1'b0;
						send_byte(item, 1'b0, NoResult);
						count++;
					end
				end
			end
		end
		quiet = 1'b0;

		byte_valid <= 1'b0;
		while (frame_results_due.size() != 0) begin
			@(posedge clk);
		end
		repeat (8) @(posedge clk);
		if (fail_cnt == 0) begin
			$display("tb_radio_frame_receive_checker_top: PASS");
		end else begin
			$display("tb_radio_frame_receive_checker_top: FAIL");
		end
		$finish;
	end

endmodule

### sim.f
sv/rfrc_pkg.sv
sv/rfrc_regs.sv
sv/rfrc_core.sv
sv/radio_frame_receive_checker_top.sv
sv/rfrc_checker.sv
test/tb_radio_frame_receive_checker_top.sv
